>>> rtl/core/jfps_pkg.sv
package jfps_pkg;

   localparam int MAX_COLS      = 1024;
   localparam int SAMPLE_BITS   = 32;
   localparam int COL_BITS      = $clog2(MAX_COLS);
   localparam int ROW_BITS      = 16;
   localparam int CFG_COLS_BITS = 11;
   localparam int CSR_DATA_BITS = 16;
   localparam int SUM_BITS      = SAMPLE_BITS + 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic CSR_GRID_COLS = 1'b0;
   localparam logic CSR_GRID_ROWS = 1'b1;

   localparam logic [CFG_COLS_BITS-1:0] GRID_COLS_RESET = CFG_COLS_BITS'(1024);
   localparam logic [ROW_BITS-1:0]      GRID_ROWS_RESET = ROW_BITS'(1024);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] east;
      logic signed [SAMPLE_BITS-1:0] south;
      logic signed [SAMPLE_BITS-1:0] north_next;
   } ls_rd_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic [ROW_BITS-1:0]           out_row;
      logic [COL_BITS-1:0]           out_col;
      logic                          last_of_frame;
   } rsp_type;

endpackage

>>> rtl/core/jfps_line_store.sv
module jfps_line_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               acc,
   input  logic [jfps_pkg::COL_BITS-1:0]      col,
   input  logic [jfps_pkg::SAMPLE_BITS-1:0]   sample,
   output jfps_pkg::ls_rd_type                rd
);

   logic [jfps_pkg::SAMPLE_BITS-1:0] p_mem [jfps_pkg::MAX_COLS];
   logic [jfps_pkg::SAMPLE_BITS-1:0] o_mem [jfps_pkg::MAX_COLS];

   logic [jfps_pkg::COL_BITS-1:0]    col_back;
   logic [jfps_pkg::SAMPLE_BITS-1:0] p_here_ff;
   logic [jfps_pkg::SAMPLE_BITS-1:0] p_back_ff;
   logic [jfps_pkg::SAMPLE_BITS-1:0] o_rd_ff;
   logic [jfps_pkg::SAMPLE_BITS-1:0] fwd_data_ff;
   logic                             fwd_ff;
   logic                             o_wr_ff;
   logic [jfps_pkg::COL_BITS-1:0]    o_col_ff;

   assign col_back = (col == '0) ? jfps_pkg::COL_BITS'(jfps_pkg::MAX_COLS - 1)
                                 : col - jfps_pkg::COL_BITS'(1);

   always_ff @(posedge clock) begin
      if (acc) begin
         p_mem[col] <= sample;
         p_here_ff  <= p_mem[col];
         p_back_ff  <= p_mem[col_back];
      end
   end

   // The older row takes the previous row's entry in the cycle after the read.
   always_ff @(posedge clock) begin
      if (o_wr_ff) begin
         o_mem[o_col_ff] <= p_here_ff;
      end
      if (acc) begin
         o_rd_ff <= o_mem[col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ff <= 1'b0;
      end else begin
         o_wr_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         o_col_ff    <= col;
         fwd_ff      <= o_wr_ff && (o_col_ff == col);
         fwd_data_ff <= p_here_ff;
      end
   end

   assign rd.east       = $signed(p_here_ff);
   assign rd.south      = $signed(p_back_ff);
   assign rd.north_next = fwd_ff ? $signed(fwd_data_ff) : $signed(o_rd_ff);

endmodule

>>> rtl/core/jfps_rsp_queue.sv
module jfps_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  jfps_pkg::rsp_type                 push_data,
   input  logic                              pop,
   output logic                              valid,
   output jfps_pkg::rsp_type                 head,
   output logic [jfps_pkg::QCNT_BITS-1:0]    count
);

   jfps_pkg::rsp_type                q_ff [jfps_pkg::QUEUE_DEPTH];
   logic [jfps_pkg::QPTR_BITS-1:0]   wr_ptr_ff;
   logic [jfps_pkg::QPTR_BITS-1:0]   rd_ptr_ff;
   logic [jfps_pkg::QCNT_BITS-1:0]   cnt_ff;
   logic [jfps_pkg::QPTR_BITS-1:0]   wr_ptr_in;
   logic [jfps_pkg::QPTR_BITS-1:0]   rd_ptr_in;
   logic [jfps_pkg::QCNT_BITS-1:0]   cnt_in;

   localparam logic [jfps_pkg::QPTR_BITS-1:0] LAST_PTR =
      jfps_pkg::QPTR_BITS'(jfps_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + jfps_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + jfps_pkg::QPTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + jfps_pkg::QCNT_BITS'(1);
         2'b01:   cnt_in = cnt_ff - jfps_pkg::QCNT_BITS'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = (cnt_ff != '0);
   assign head  = q_ff[rd_ptr_ff];
   assign count = cnt_ff;

endmodule

>>> rtl/core/jacobi_four_point_stencil_top.sv
// A result passes through the stage-1 registers and the result queue before it reaches the rsp_ ports.
// Throughput: one sample per cycle while req_stall is low; the two line stores are read and written once per cycle.
// A four-entry result queue absorbs rsp_stall; req_stall rises once it could fill.
// Reset clears the position counters, the neighbor window and the result queue and
// restores grid_cols and grid_rows to 1024. The line stores are not cleared.
module jacobi_four_point_stencil_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [jfps_pkg::SAMPLE_BITS-1:0]   req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [jfps_pkg::SAMPLE_BITS-1:0]   rsp_average,
   output logic [jfps_pkg::ROW_BITS-1:0]             rsp_out_row,
   output logic [jfps_pkg::COL_BITS-1:0]             rsp_out_col,
   output logic                                      rsp_last_of_frame,
   input  logic                                      csr_wr_en,
   input  logic                                      csr_index,
   input  logic [jfps_pkg::CSR_DATA_BITS-1:0]        csr_wr_data
);

   logic [jfps_pkg::CFG_COLS_BITS-1:0] grid_cols_ff;
   logic [jfps_pkg::ROW_BITS-1:0]      grid_rows_ff;
   logic [jfps_pkg::COL_BITS-1:0]      col_cnt_ff;
   logic [jfps_pkg::ROW_BITS-1:0]      row_cnt_ff;
   logic [jfps_pkg::COL_BITS-1:0]      col_cnt_in;
   logic [jfps_pkg::ROW_BITS-1:0]      row_cnt_in;

   logic [jfps_pkg::COL_BITS-1:0]      last_col_idx;
   logic [jfps_pkg::ROW_BITS-1:0]      last_row_idx;
   logic [jfps_pkg::COL_BITS-1:0]      col_eff;
   logic                               last_col;
   logic                               last_row;
   logic                               has_result;
   logic                               req_acc;

   logic                               s1_valid_ff;
   logic                               s1_has_ff;
   logic [jfps_pkg::ROW_BITS-1:0]      s1_row_ff;
   logic [jfps_pkg::COL_BITS-1:0]      s1_col_ff;
   logic                               s1_last_ff;

   logic signed [jfps_pkg::SAMPLE_BITS-1:0] north_delay_ff;
   logic signed [jfps_pkg::SAMPLE_BITS-1:0] win1_ff;
   logic signed [jfps_pkg::SAMPLE_BITS-1:0] win2_ff;
   logic signed [jfps_pkg::SUM_BITS-1:0]    sum;

   jfps_pkg::ls_rd_type                ls_rd;
   jfps_pkg::rsp_type                  push_data;
   jfps_pkg::rsp_type                  head;
   logic                               push;
   logic                               pop;
   logic [jfps_pkg::QCNT_BITS-1:0]     q_cnt;
   logic [jfps_pkg::QCNT_BITS:0]       q_need;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= jfps_pkg::GRID_COLS_RESET;
         grid_rows_ff <= jfps_pkg::GRID_ROWS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            jfps_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wr_data[jfps_pkg::CFG_COLS_BITS-1:0];
            jfps_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wr_data[jfps_pkg::ROW_BITS-1:0];
            default:                 grid_cols_ff <= grid_cols_ff;
         endcase
      end
   end

   always_comb begin
      if (grid_cols_ff < jfps_pkg::CFG_COLS_BITS'(3)) begin
         last_col_idx = jfps_pkg::COL_BITS'(2);
      end else if (grid_cols_ff > jfps_pkg::CFG_COLS_BITS'(jfps_pkg::MAX_COLS)) begin
         last_col_idx = jfps_pkg::COL_BITS'(jfps_pkg::MAX_COLS - 1);
      end else begin
         last_col_idx = jfps_pkg::COL_BITS'(grid_cols_ff - jfps_pkg::CFG_COLS_BITS'(1));
      end
      if (grid_rows_ff < jfps_pkg::ROW_BITS'(3)) begin
         last_row_idx = jfps_pkg::ROW_BITS'(2);
      end else begin
         last_row_idx = grid_rows_ff - jfps_pkg::ROW_BITS'(1);
      end

      last_col   = (col_cnt_ff >= last_col_idx);
      col_eff    = last_col ? last_col_idx : col_cnt_ff;
      last_row   = (row_cnt_ff >= last_row_idx);
      has_result = (row_cnt_ff >= jfps_pkg::ROW_BITS'(2)) &&
                   (col_eff >= jfps_pkg::COL_BITS'(2));

      if (last_col) begin
         col_cnt_in = '0;
         row_cnt_in = last_row ? '0 : row_cnt_ff + jfps_pkg::ROW_BITS'(1);
      end else begin
         col_cnt_in = col_eff + jfps_pkg::COL_BITS'(1);
         row_cnt_in = row_cnt_ff;
      end
   end

   // A new transaction is taken only if the queue can hold it and the result ahead of it.
   assign q_need    = {1'b0, q_cnt} + (jfps_pkg::QCNT_BITS+1)'(s1_valid_ff && s1_has_ff);
   assign req_stall = (q_need > (jfps_pkg::QCNT_BITS+1)'(jfps_pkg::QUEUE_DEPTH - 1));
   assign req_acc   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc;
         if (req_acc) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_has_ff  <= has_result;
         s1_row_ff  <= row_cnt_ff - jfps_pkg::ROW_BITS'(1);
         s1_col_ff  <= col_eff - jfps_pkg::COL_BITS'(1);
         s1_last_ff <= last_col && last_row;
      end
   end

   jfps_line_store u_line_store (
      .clock  (clock),
      .reset  (reset),
      .acc    (req_acc),
      .col    (col_eff),
      .sample (req_sample),
      .rd     (ls_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         north_delay_ff <= '0;
         win1_ff        <= '0;
         win2_ff        <= '0;
      end else if (s1_valid_ff) begin
         north_delay_ff <= ls_rd.north_next;
         win1_ff        <= win2_ff;
         win2_ff        <= ls_rd.east;
      end
   end

   assign sum = jfps_pkg::SUM_BITS'(north_delay_ff) + jfps_pkg::SUM_BITS'(ls_rd.south) +
                jfps_pkg::SUM_BITS'(ls_rd.east) + jfps_pkg::SUM_BITS'(win1_ff);

   assign push                    = s1_valid_ff && s1_has_ff;
   assign push_data.average       = sum[jfps_pkg::SUM_BITS-1:2];
   assign push_data.out_row       = s1_row_ff;
   assign push_data.out_col       = s1_col_ff;
   assign push_data.last_of_frame = s1_last_ff;
   assign pop                     = rsp_valid && !rsp_stall;

   jfps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .valid     (rsp_valid),
      .head      (head),
      .count     (q_cnt)
   );

   assign rsp_average       = head.average;
   assign rsp_out_row       = head.out_row;
   assign rsp_out_col       = head.out_col;
   assign rsp_last_of_frame = head.last_of_frame;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt <= jfps_pkg::QCNT_BITS'(jfps_pkg::QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_cnt < jfps_pkg::QCNT_BITS'(jfps_pkg::QUEUE_DEPTH)) || pop)
      else $error("result pushed into a full queue");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (push && s1_last_ff) |-> (col_cnt_ff == '0) && (row_cnt_ff == '0))
      else $error("position did not return to the frame start after the last point");

endmodule

>>> bench/tb_top.sv
module tb_top;
   import jfps_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 1150;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_average;
   logic [ROW_BITS-1:0] rsp_out_row;
   logic [COL_BITS-1:0] rsp_out_col;
   logic rsp_last_of_frame;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_GRID_COLS;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   logic signed [SAMPLE_BITS-1:0] upper_line [0:MAX_COLS-1];
   logic signed [SAMPLE_BITS-1:0] older_line [0:MAX_COLS-1];
   logic signed [SAMPLE_BITS-1:0] row_window [0:2];
   logic signed [SAMPLE_BITS-1:0] north_hold;
   logic [COL_BITS-1:0] col_pos;
   logic [ROW_BITS-1:0] row_pos;
   logic [CFG_COLS_BITS-1:0] cfg_cols;
   logic [ROW_BITS-1:0] cfg_rows;

   rsp_type expected_points [$];
   rsp_type wanted;
   int error_count = 0;
   int cycle_count = 0;
   int stall_len;
   bit req_idling = 1'b0;
   bit rsp_idling = 1'b0;

   jacobi_four_point_stencil_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_average(rsp_average),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_last_of_frame(rsp_last_of_frame),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return -1;
         3: return 0;
         4: return $signed(32'($urandom_range(0, 7))) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic stencil_clear();
      for (int i = 0; i < MAX_COLS; i++) begin
         upper_line[i] = '0;
         older_line[i] = '0;
      end
      for (int i = 0; i < 3; i++) row_window[i] = '0;
      north_hold = '0;
      col_pos = '0;
      row_pos = '0;
      cfg_cols = GRID_COLS_RESET;
      cfg_rows = GRID_ROWS_RESET;
   endtask

   // Advances the grid position by one sample and queues the interior point it completes.
   task automatic stencil_advance(input logic signed [SAMPLE_BITS-1:0] value);
      int unsigned cols, rows, c, r, ci;
      logic signed [SAMPLE_BITS-1:0] north, south, east, west;
      logic signed [SUM_BITS-1:0] total;
      bit last_col, last_row;
      rsp_type point;
      cols = (cfg_cols < 3) ? 3 : ((cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols);
      rows = (cfg_rows < 3) ? 3 : cfg_rows;
      c = col_pos;
      r = row_pos;
      last_col = (c >= cols - 1);
      if (last_col) c = cols - 1;
      last_row = (r >= rows - 1);
      ci = c % MAX_COLS;
      north = north_hold;
      north_hold = older_line[ci];
      south = upper_line[(ci + MAX_COLS - 1) % MAX_COLS];
      row_window[0] = row_window[1];
      row_window[1] = row_window[2];
      row_window[2] = upper_line[ci];
      east = row_window[2];
      west = row_window[0];
      older_line[ci] = upper_line[ci];
      upper_line[ci] = value;
      if (r >= 2 && c >= 2) begin
         total = north + south + east + west;
         point.average = SAMPLE_BITS'(total >>> 2);
         point.out_row = ROW_BITS'(r - 1);
         point.out_col = COL_BITS'(c - 1);
         point.last_of_frame = last_col && last_row;
         expected_points.push_back(point);
      end
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : ROW_BITS'(r + 1);
      end else begin
         col_pos = COL_BITS'(c + 1);
      end
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = req_idling ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stencil_advance(value);
      @(negedge clock);
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_grid(input int unsigned cols, input int unsigned rows);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GRID_COLS;
      csr_wr_data <= CSR_DATA_BITS'(cols);
      @(negedge clock);
      csr_index <= CSR_GRID_ROWS;
      csr_wr_data <= CSR_DATA_BITS'(rows);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_cols = CFG_COLS_BITS'(cols);
      cfg_rows = ROW_BITS'(rows);
   endtask

   task automatic send_frame(input int unsigned cols, input int unsigned rows);
      int unsigned eff_cols, eff_rows;
      eff_cols = (cols % 2048 < 3) ? 3 : ((cols % 2048 > MAX_COLS) ? MAX_COLS : cols % 2048);
      eff_rows = (rows < 3) ? 3 : rows;
      write_grid(cols, rows);
      repeat (eff_cols * eff_rows) send_sample(pick_sample());
      drain_results(4);
   endtask

   task automatic test_directed_extremes();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      // The first two samples go in under the reset grid size.
      repeat (2) send_sample(SAMPLE_MIN);
      drain_results(4);
      write_grid(0, 0);
      repeat (7) send_sample(SAMPLE_MIN);
      drain_results(4);
      write_grid(4, 1);
      send_sample(32'sh1234_5678);
      send_sample(SAMPLE_MAX);
      send_sample(-1);
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(0);
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(0);
      send_sample(32'shA5A5_A5A5);
      drain_results(4);
   endtask

   task automatic test_wide_grid();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      send_frame(MAX_COLS, 3);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      send_frame(16'hFFFF, 3);
   endtask

   task automatic test_random_frames();
      int sent;
      int unsigned cols, rows;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: cols = $urandom_range(0, 2);
            7, 8, 9: cols = $urandom_range(13, 60);
            default: cols = $urandom_range(3, 12);
         endcase
         rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         send_frame(cols, rows);
         sent += ((cols < 3) ? 3 : cols) * ((rows < 3) ? 3 : rows);
      end
   endtask

   task automatic test_midframe_changes();
      int unsigned cols, rows;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      write_grid(20, 40);
      repeat (53) send_sample(pick_sample());
      drain_results(4);
      // The column position is past the new last column, so the row wraps.
      write_grid(8, 40);
      repeat (30) send_sample(pick_sample());
      drain_results(4);
      // The row position is past the new last row, so the frame ends with this row.
      write_grid(8, 3);
      repeat (20) send_sample(pick_sample());
      drain_results(4);
      repeat (14) begin
         case ($urandom_range(0, 5))
            0: cols = $urandom_range(0, 2);
            1: cols = 16'hFFFF;
            default: cols = $urandom_range(3, 30);
         endcase
         case ($urandom_range(0, 4))
            0: rows = $urandom_range(0, 2);
            1: rows = 16'hFFFF;
            default: rows = $urandom_range(3, 12);
         endcase
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         write_grid(cols, rows);
         repeat ($urandom_range(1, 120)) send_sample(pick_sample());
         drain_results(4);
      end
   endtask

   always begin
      @(negedge clock);
      if (rsp_idling) begin
         stall_len = idle_length();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each result transaction is compared with the oldest expected interior point.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result: average %0d row %0d col %0d", rsp_average,
                   rsp_out_row, rsp_out_col);
            error_count++;
         end else begin
            wanted = expected_points.pop_front();
            if (rsp_average !== wanted.average) begin
               $error("average: expected %0d, actual %0d", wanted.average, rsp_average);
               error_count++;
            end
            if (rsp_out_row !== wanted.out_row) begin
               $error("out_row: expected %0d, actual %0d", wanted.out_row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== wanted.out_col) begin
               $error("out_col: expected %0d, actual %0d", wanted.out_col, rsp_out_col);
               error_count++;
            end
            if (rsp_last_of_frame !== wanted.last_of_frame) begin
               $error("last_of_frame: expected %0d, actual %0d", wanted.last_of_frame,
                      rsp_last_of_frame);
               error_count++;
            end
         end
      end
   end

   initial begin
      stencil_clear();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_extremes();
      test_wide_grid();
      test_random_frames();
      test_midframe_changes();
      drain_results(8);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/jfps_pkg.sv
rtl/core/jfps_line_store.sv
rtl/core/jfps_rsp_queue.sv
rtl/core/jacobi_four_point_stencil_top.sv
bench/tb_top.sv
